/* design/iida_pkg.sv */
// Shared command, status and field-width constants for the indexed insert/delete array.
package iida_pkg;

    // Command codes carried on the input tuser field.
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_REM_IDX = 3'd2;
    localparam logic [2:0] OP_REM_VAL = 3'd3;
    localparam logic [2:0] OP_FIND    = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Field widths of the stream payloads.
    localparam int OP_W    = 3;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int MIDX_W  = 4;
    localparam int CNT5_W  = 5;
    localparam int STAT_W  = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    // A find-all run reports at most this many matches.
    localparam int MAX_RUN = 16;
    localparam int RUN_W   = 5;

endpackage

/* design/indexed_insert_delete_array.sv */
// Indexed insert/delete array: an ordered word store in one synchronous memory with a sequencer.
//
// The block keeps an ordered list of up to CAPACITY words of DATA_WIDTH bits in a
// single-port-write, single-port-read memory with a registered read. Each input
// transfer carries one command; the block takes one command at a time and answers with one
// result transfer, except find all, which answers with one transfer per matching entry (at
// most 16) and marks the final one with tlast. All the cost comes from walking the memory one
// entry per cycle through the read-modify-write pipe, except while find all waits for a held
// match to leave. Read fetches a single entry; clear, append, rejected commands and undefined
// opcodes walk none; insert at index p walks entries count - 1 down to p, remove at index p
// walks entries p up to count - 1, and remove by value and find all walk all count entries
// (find all fewer when it stops at sixteen matches), where count is the number of stored entries. Any
// command stretches further while the previous result still waits in the output register,
// and find all also while a held match cannot leave. A finished result sits in the output
// register, so the next command is taken as soon as the sequencer is back in idle, even
// while that result still waits to be taken. Entries above the current count are never
// read, so the memory needs no clearing after reset.
module indexed_insert_delete_array #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0 up: position[4:0], value[36:5], zero fill[39:37].
    input  logic [iida_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0 up: op[2:0].
    input  logic [iida_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0 up: read_value[31:0], match_index[35:32], found[36],
    // removed_count[41:37], entry_count[46:42], status[48:47], zero fill[55:49].
    output logic [iida_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);
    import iida_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [7:0] CAP8 = 8'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INSW,
        S_RDW,
        S_RMI,
        S_RMV,
        S_FND,
        S_EMIT
    } state_t;

    // Sequencer state.
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        s_reg, s_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic [RUN_W-1:0]        n_reg, n_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [DATA_WIDTH-1:0]   val_reg, val_next;

    // Pending result of the current command.
    logic [VAL_W-1:0]        res_value_reg, res_value_next;
    logic [MIDX_W-1:0]       res_idx_reg, res_idx_next;
    logic                    res_found_reg, res_found_next;
    logic [CNT5_W-1:0]       res_removed_reg, res_removed_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;

    // Output register.
    logic                    out_vld_reg, out_vld_next;
    logic [VAL_W-1:0]        out_value_reg, out_value_next;
    logic [MIDX_W-1:0]       out_idx_reg, out_idx_next;
    logic                    out_found_reg, out_found_next;
    logic [CNT5_W-1:0]       out_removed_reg, out_removed_next;
    logic [CNT5_W-1:0]       out_count_reg, out_count_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic                    out_last_reg, out_last_next;

    // Memory and its ports.
    logic [DATA_WIDTH-1:0]   mem [CAPACITY];
    logic [DATA_WIDTH-1:0]   rd_data_reg;
    logic                    mem_rd_en;
    logic [IDX_W-1:0]        mem_rd_addr;
    logic                    mem_wr_en;
    logic [IDX_W-1:0]        mem_wr_addr;
    logic [DATA_WIDTH-1:0]   mem_wr_data;

    // Field unpacking and width conversions.
    logic [OP_W-1:0]         in_op;
    logic [7:0]              in_pos8;
    logic [63:0]             in_val64;
    logic [DATA_WIDTH-1:0]   in_val;
    logic [63:0]             rd_ext64;
    logic [VAL_W-1:0]        rd_value;
    logic [7:0]              s_ext8;
    logic [7:0]              s_plus8;
    logic [7:0]              count_ext8;
    logic [7:0]              count_m1_8;
    logic [CNT_W-1:0]        j_inc;
    logic [7:0]              removed8;
    logic                    out_free;
    logic                    keep;
    logic                    match;

    assign in_op      = s_axis_tuser;
    assign in_pos8    = 8'(s_axis_tdata[POS_W-1:0]);
    assign in_val64   = 64'(s_axis_tdata[POS_W+VAL_W-1:POS_W]);
    assign in_val     = in_val64[DATA_WIDTH-1:0];
    assign rd_ext64   = 64'(rd_data_reg);
    assign rd_value   = rd_ext64[VAL_W-1:0];
    assign s_ext8     = 8'(s_reg);
    assign s_plus8    = s_ext8 + 8'd1;
    assign count_ext8 = 8'(count_reg);
    assign count_m1_8 = count_ext8 - 8'd1;
    assign keep       = (rd_data_reg != val_reg);
    assign match      = (rd_data_reg == val_reg);
    assign j_inc      = keep ? (j_reg + CNT_W'(1)) : j_reg;
    assign removed8   = 8'(count_reg - j_inc);
    assign out_free   = !out_vld_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_status_reg, out_count_reg, out_removed_reg,
                            out_found_reg, out_idx_reg, out_value_reg};

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        s_next           = s_reg;
        j_next           = j_reg;
        n_next           = n_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        res_value_next   = res_value_reg;
        res_idx_next     = res_idx_reg;
        res_found_next   = res_found_reg;
        res_removed_next = res_removed_reg;
        res_status_next  = res_status_reg;
        out_vld_next     = out_vld_reg && !m_axis_tready;
        out_value_next   = out_value_reg;
        out_idx_next     = out_idx_reg;
        out_found_next   = out_found_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = '0;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = '0;
        mem_wr_data      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pos_next         = in_pos8[IDX_W-1:0];
                    val_next         = in_val;
                    s_next           = '0;
                    j_next           = '0;
                    n_next           = '0;
                    res_value_next   = '0;
                    res_idx_next     = '0;
                    res_found_next   = 1'b0;
                    res_removed_next = '0;
                    res_status_next  = ST_OK;
                    state_next       = S_EMIT;
                    case (in_op)
                        OP_INSERT:
                        begin
                            if (count_ext8 >= CAP8)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (in_pos8 > count_ext8)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (in_pos8 == count_ext8)
                            begin
                                // Append needs no shift.
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = in_pos8[IDX_W-1:0];
                                mem_wr_data = in_val;
                                count_next  = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = count_m1_8[IDX_W-1:0];
                                s_next      = count_m1_8[IDX_W-1:0];
                                state_next  = S_INS;
                            end
                        end
                        OP_READ,
                        OP_REM_IDX:
                        begin
                            if (in_pos8 >= count_ext8)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = in_pos8[IDX_W-1:0];
                                s_next      = in_pos8[IDX_W-1:0];
                                state_next  = (in_op == OP_READ) ? S_RDW : S_RMI;
                            end
                        end
                        OP_REM_VAL,
                        OP_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                state_next  = (in_op == OP_FIND) ? S_FND : S_RMV;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                // Move entry s up by one while fetching entry s - 1.
                mem_wr_en   = 1'b1;
                mem_wr_addr = s_plus8[IDX_W-1:0];
                mem_wr_data = rd_data_reg;
                if (s_reg == pos_reg)
                begin
                    state_next = S_INSW;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = s_reg - IDX_W'(1);
                    s_next      = s_reg - IDX_W'(1);
                end
            end
            S_INSW:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_reg;
                mem_wr_data = val_reg;
                count_next  = count_reg + CNT_W'(1);
                state_next  = S_EMIT;
            end
            S_RDW:
            begin
                res_value_next = rd_value;
                state_next     = S_EMIT;
            end
            S_RMI:
            begin
                // The first word fetched is the one removed; later ones move down.
                if (s_reg == pos_reg)
                begin
                    res_value_next = rd_value;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = s_reg - IDX_W'(1);
                    mem_wr_data = rd_data_reg;
                end
                if (s_plus8 < count_ext8)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = s_plus8[IDX_W-1:0];
                    s_next      = s_plus8[IDX_W-1:0];
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end
            S_RMV:
            begin
                // Compaction: survivors are written at j, which never passes s.
                if (keep)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = j_reg[IDX_W-1:0];
                    mem_wr_data = rd_data_reg;
                end
                j_next = j_inc;
                if (s_plus8 < count_ext8)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = s_plus8[IDX_W-1:0];
                    s_next      = s_plus8[IDX_W-1:0];
                end
                else
                begin
                    count_next       = j_inc;
                    res_removed_next = removed8[CNT5_W-1:0];
                    state_next       = S_EMIT;
                end
            end
            S_FND:
            begin
                // The latest match is held back in the result registers so that the
                // final one can carry tlast; a new match pushes the held one out.
                if (!(match && res_found_reg && !out_free))
                begin
                    if (match && res_found_reg)
                    begin
                        out_vld_next     = 1'b1;
                        out_value_next   = '0;
                        out_idx_next     = res_idx_reg;
                        out_found_next   = 1'b1;
                        out_removed_next = '0;
                        out_count_next   = count_ext8[CNT5_W-1:0];
                        out_status_next  = ST_OK;
                        out_last_next    = 1'b0;
                    end
                    if (match)
                    begin
                        res_idx_next   = s_ext8[MIDX_W-1:0];
                        res_found_next = 1'b1;
                        n_next         = n_reg + RUN_W'(1);
                    end
                    if ((s_plus8 >= count_ext8) || (match && (n_reg == RUN_W'(MAX_RUN - 1))))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = s_plus8[IDX_W-1:0];
                        s_next      = s_plus8[IDX_W-1:0];
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next     = 1'b1;
                    out_value_next   = res_value_reg;
                    out_idx_next     = res_idx_reg;
                    out_found_next   = res_found_reg;
                    out_removed_next = res_removed_reg;
                    out_count_next   = count_ext8[CNT5_W-1:0];
                    out_status_next  = res_status_reg;
                    out_last_next    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            s_reg           <= '0;
            j_reg           <= '0;
            n_reg           <= '0;
            pos_reg         <= '0;
            val_reg         <= '0;
            res_value_reg   <= '0;
            res_idx_reg     <= '0;
            res_found_reg   <= 1'b0;
            res_removed_reg <= '0;
            res_status_reg  <= ST_OK;
            out_vld_reg     <= 1'b0;
            out_value_reg   <= '0;
            out_idx_reg     <= '0;
            out_found_reg   <= 1'b0;
            out_removed_reg <= '0;
            out_count_reg   <= '0;
            out_status_reg  <= ST_OK;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            s_reg           <= s_next;
            j_reg           <= j_next;
            n_reg           <= n_next;
            pos_reg         <= pos_next;
            val_reg         <= val_next;
            res_value_reg   <= res_value_next;
            res_idx_reg     <= res_idx_next;
            res_found_reg   <= res_found_next;
            res_removed_reg <= res_removed_next;
            res_status_reg  <= res_status_next;
            out_vld_reg     <= out_vld_next;
            out_value_reg   <= out_value_next;
            out_idx_reg     <= out_idx_next;
            out_found_reg   <= out_found_next;
            out_removed_reg <= out_removed_next;
            out_count_reg   <= out_count_next;
            out_status_reg  <= out_status_next;
            out_last_reg    <= out_last_next;
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

`ifndef SYNTHESIS
    // The stored count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_ext8 <= CAP8)
        else $error("entry count above capacity");

    // The schedule never reads and writes the same entry in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
        else $error("memory read and write collide");

    // Only find all produces results without tlast, and each of them is a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_last_reg) |-> (out_found_reg && (state_reg == S_FND
            || state_reg == S_EMIT)))
        else $error("non-final result that is not a find-all match");

    // A held result stays put while the output side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_axis_tready) |=> (out_vld_reg && $stable(m_axis_tdata)))
        else $error("output register changed under a stall");
`endif

endmodule

/* tb/iida_checker.sv */
// Checker for the indexed insert/delete array: tracks the array contents and compares results.
module iida_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    input  logic                             cmd_ready,
    input  logic [iida_pkg::IN_TDATA_W-1:0]  cmd_data,
    input  logic [iida_pkg::OP_W-1:0]        cmd_op,
    input  logic                             res_valid,
    input  logic                             res_ready,
    input  logic [iida_pkg::OUT_TDATA_W-1:0] res_data,
    input  logic                             res_last,
    output int                               errors,
    output int                               pending
);
    import iida_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [MIDX_W-1:0] match_index;
        logic              found;
        logic [CNT5_W-1:0] removed_count;
        logic [CNT5_W-1:0] entry_count;
        logic [STAT_W-1:0] status;
        logic              last;
    } array_result_t;

    // Shadow of the block's memory and fill level.
    logic [VAL_W-1:0] shadow_words [SLOTS];
    int               shadow_count = 0;
    array_result_t    awaited_results [$];
    int               mismatches = 0;

    assign errors = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s: expected %0h, got %0h", name, want, got));
    endtask

    // Applies one command to the shadow array and queues the results it must produce.
    task automatic apply_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic [VAL_W-1:0] val);
        array_result_t res;
        array_result_t hit;
        int            i;
        int            kept;
        int            hits;
        bit            run_queued;
        res        = '0;
        res.last   = 1'b1;
        res.status = ST_OK;
        run_queued = 1'b0;
        case (op)
            OP_INSERT:
            begin
                // A full array is reported before the index is looked at.
                if (shadow_count >= SLOTS)
                    res.status = ST_FULL;
                else if (int'(pos) > shadow_count)
                    res.status = ST_RANGE;
                else
                begin
                    for (i = shadow_count; i > int'(pos); i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = val;
                    shadow_count++;
                end
            end
            OP_READ:
            begin
                if (int'(pos) >= shadow_count)
                    res.status = ST_RANGE;
                else
                    res.read_value = shadow_words[pos];
            end
            OP_REM_IDX:
            begin
                if (int'(pos) >= shadow_count)
                    res.status = ST_RANGE;
                else
                begin
                    res.read_value = shadow_words[pos];
                    for (i = int'(pos); i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                end
            end
            OP_REM_VAL:
            begin
                kept = 0;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_words[i] != val)
                    begin
                        shadow_words[kept] = shadow_words[i];
                        kept++;
                    end
                end
                res.removed_count = CNT5_W'(shadow_count - kept);
                shadow_count      = kept;
            end
            OP_FIND:
            begin
                hits = 0;
                for (i = 0; i < shadow_count && hits < MAX_RUN; i++)
                begin
                    if (shadow_words[i] == val)
                    begin
                        hit             = '0;
                        hit.match_index = MIDX_W'(i);
                        hit.found       = 1'b1;
                        hit.entry_count = CNT5_W'(shadow_count);
                        hit.status      = ST_OK;
                        awaited_results.push_back(hit);
                        hits++;
                    end
                end
                // With no match a single empty result closes the run.
                if (hits != 0)
                begin
                    awaited_results[awaited_results.size()-1].last = 1'b1;
                    run_queued = 1'b1;
                end
            end
            OP_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        if (!run_queued)
        begin
            res.entry_count = CNT5_W'(shadow_count);
            awaited_results.push_back(res);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        array_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            shadow_count = 0;
            pending <= 0;
        end
        else
        begin
            // Results are retired before a command on the same edge is predicted.
            if (res_valid && res_ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("unexpected result transfer, tdata %0h",
                                              res_data));
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("read_value", want.read_value, res_data[31:0]);
                    check_field("match_index", want.match_index, res_data[35:32]);
                    check_field("found", want.found, res_data[36]);
                    check_field("removed_count", want.removed_count, res_data[41:37]);
                    check_field("entry_count", want.entry_count, res_data[46:42]);
                    check_field("status", want.status, res_data[48:47]);
                    check_field("last", want.last, res_last);
                end
            end
            if (cmd_valid && cmd_ready)
                apply_command(cmd_op, cmd_data[POS_W-1:0], cmd_data[POS_W +: VAL_W]);
            pending <= awaited_results.size();
        end
    end

endmodule

/* tb/tb_indexed_insert_delete_array.sv */
// Top of the indexed insert/delete array testbench: clock, reset, stimulus and verdict.
module tb_indexed_insert_delete_array;
    import iida_pkg::*;

    // Opcodes that the block has no command for; it must answer them with a plain result.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_CMDS    = 440;
    // The receiver holds off once, after this many command transfers, for HOLD_CYCLES.
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 200;
    // Both sides run without any idling while the transfer count is in this window.
    localparam int CALM_FROM      = 300;
    localparam int CALM_TO        = 380;
    // The longest legal silence is the hold-off plus one full-array walk; this is
    // many times that.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0 up: position[4:0], value[36:5], zero fill[39:37].
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // Fields from bit 0 up: op[2:0].
    logic [OP_W-1:0]        s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0 up: read_value[31:0], match_index[35:32], found[36],
    // removed_count[41:37], entry_count[46:42], status[48:47], zero fill[55:49].
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    int  mismatch_count;
    int  results_owed;
    int  cmds_sent = 0;
    wire calm      = (cmds_sent >= CALM_FROM) && (cmds_sent < CALM_TO);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    indexed_insert_delete_array DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    iida_checker scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd_data  (s_axis_tdata),
        .cmd_op    (s_axis_tuser),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (m_axis_tdata),
        .res_last  (m_axis_tlast),
        .errors    (mismatch_count),
        .pending   (results_owed)
    );

    // Result side. Ready changes only on falling edges. Outside the calm window it drops
    // with a chance of about 31 percent. Once, the receiver stops taking results for a long
    // stretch while commands keep coming, so the block backs up and has to stall its
    // command input.
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (!hold_done && cmds_sent >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 31);
    end

    // Offers one command and returns on the falling edge after its transfer. Idle gaps
    // are inserted before the offer; valid is never dropped and raised in the same step.
    task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        while (!calm && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W - VAL_W - POS_W){1'b0}}, val, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        cmds_sent++;
        @(negedge clk);
    endtask

    // Watchdog: ends the run if neither channel moves a transfer for too long.
    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int               n;
        int               pick;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. On an empty array every index is out of range, find reports
        // no match and remove by value removes nothing.
        send_command(OP_READ, 5'd0, 32'h0);
        send_command(OP_REM_IDX, 5'd0, 32'h0);
        send_command(OP_FIND, 5'd0, 32'h0);
        send_command(OP_REM_VAL, 5'd0, 32'h0);
        send_command(OP_INSERT, 5'd1, 32'h1234_5678);
        // Insert at the front, append at the end, then insert in front to shift.
        send_command(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_command(OP_INSERT, 5'd1, 32'h0000_0000);
        send_command(OP_INSERT, 5'd0, 32'h0000_0005);
        send_command(OP_READ, 5'd2, 32'h0);
        send_command(OP_READ, 5'd3, 32'h0);
        send_command(OP_READ, 5'd31, 32'h0);
        send_command(OP_FIND, 5'd0, 32'h0000_0005);
        send_command(OP_REM_IDX, 5'd2, 32'h0);
        send_command(OP_CLEAR, 5'd0, 32'h0);
        // Fill to capacity with one value, alternating front inserts and appends.
        for (n = 0; n < 16; n++)
            send_command(OP_INSERT, (n % 2) ? POS_W'(n) : 5'd0, 32'h0000_0005);
        // Full is reported ahead of a bad index.
        send_command(OP_INSERT, 5'd0, 32'hDEAD_BEEF);
        send_command(OP_INSERT, 5'd31, 32'hDEAD_BEEF);
        send_command(OP_READ, 5'd16, 32'h0);
        // Every entry matches: a run of sixteen, the sixteenth carrying tlast.
        send_command(OP_FIND, 5'd0, 32'h0000_0005);
        send_command(OP_REM_IDX, 5'd15, 32'h0);
        send_command(OP_REM_IDX, 5'd0, 32'h0);
        send_command(OP_INSERT, 5'd14, 32'hA5A5_A5A5);
        send_command(OP_REM_VAL, 5'd0, 32'h0000_0005);
        send_command(OP_SPARE_LO, 5'd31, 32'hFFFF_FFFF);
        send_command(OP_SPARE_HI, 5'd0, 32'h0);

        // Random part. Inserts dominate so the array keeps a good depth and often runs
        // full; values mostly come from a small set so that searches and removals by
        // value hit several entries at once.
        for (n = 0; n < RANDOM_CMDS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = OP_INSERT;
            else if (pick < 55)
                op = OP_READ;
            else if (pick < 68)
                op = OP_REM_IDX;
            else if (pick < 76)
                op = OP_REM_VAL;
            else if (pick < 91)
                op = OP_FIND;
            else if (pick < 94)
                op = OP_CLEAR;
            else if (pick < 97)
                op = OP_SPARE_LO;
            else
                op = OP_SPARE_HI;

            // Mostly indexes within the array's span, some near the front, and a few
            // anywhere in the field so that every position bit toggles.
            pick = $urandom_range(9);
            if (pick < 6)
                pos = POS_W'($urandom_range(16));
            else if (pick < 9)
                pos = POS_W'($urandom_range($urandom_range(4)));
            else
                pos = POS_W'($urandom_range(31));

            case ($urandom_range(5))
                0:       val = 32'h0000_0000;
                1:       val = 32'hFFFF_FFFF;
                2:       val = 32'h0000_0005;
                3:       val = 32'hA5A5_A5A5;
                default: val = $urandom();
            endcase

            send_command(op, pos, val);
        end
        s_axis_tvalid <= 1'b0;

        // Let every awaited result come back, then watch for stray transfers a while.
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
